// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and microprogram for the modular exponentiation block
// Holds the data width, the register indexes and the control store of the
// sequencer. Each entry of the control store is one control word.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // Width of every data port
  localparam int unsigned DataW = 32;
  // Width of the configuration register index
  localparam int unsigned CfgIdxW = 2;
  // Width of the program counter
  localparam int unsigned PcW = 4;

  typedef logic [PcW-1:0] pc_t;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MODULUS  = 2'd1;

  // Datapath action of a step
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_INIT  = 3'd1,
    ACT_START = 3'd2,
    ACT_WAIT  = 3'd3,
    ACT_DONE  = 3'd4,
    ACT_ZERO  = 3'd5
  } act_e;

  // Operand pair for the modular multiplier
  typedef enum logic [1:0] {
    SRC_MSG_ONE   = 2'd0,
    SRC_ACC_BASE  = 2'd1,
    SRC_BASE_BASE = 2'd2
  } src_e;

  // Register that takes the product
  typedef enum logic {
    DST_BASE = 1'b0,
    DST_ACC  = 1'b1
  } dst_e;

  // Branch condition
  typedef enum logic [1:0] {
    BR_NEXT      = 2'd0,
    BR_MOD_SMALL = 2'd1,
    BR_EBIT_ZERO = 2'd2,
    BR_LOOP      = 2'd3
  } br_e;

  typedef struct packed {
    act_e act;
    src_e src;
    dst_e dst;
    br_e  br;
    pc_t  target;
  } ctrl_word_t;

  // Step addresses
  localparam pc_t ST_INIT     = 4'd0;
  localparam pc_t ST_RED_GO   = 4'd1;
  localparam pc_t ST_RED_WAIT = 4'd2;
  localparam pc_t ST_TEST     = 4'd3;
  localparam pc_t ST_MUL_GO   = 4'd4;
  localparam pc_t ST_MUL_WAIT = 4'd5;
  localparam pc_t ST_SQR_GO   = 4'd6;
  localparam pc_t ST_SQR_WAIT = 4'd7;
  localparam pc_t ST_LOOP     = 4'd8;
  localparam pc_t ST_DONE     = 4'd9;
  localparam pc_t ST_ZERO     = 4'd10;

  // Control store: right-to-left square-and-multiply
  function automatic ctrl_word_t micro_rom(pc_t pc);
    ctrl_word_t w;
    w = '{act: ACT_NONE, src: SRC_MSG_ONE, dst: DST_BASE, br: BR_NEXT, target: ST_INIT};
    unique case (pc)
      ST_INIT: begin
        w.act    = ACT_INIT;
        w.br     = BR_MOD_SMALL;
        w.target = ST_ZERO;
      end
      ST_RED_GO: begin
        w.act = ACT_START;
        w.src = SRC_MSG_ONE;
      end
      ST_RED_WAIT: begin
        w.act = ACT_WAIT;
        w.dst = DST_BASE;
      end
      ST_TEST: begin
        w.br     = BR_EBIT_ZERO;
        w.target = ST_SQR_GO;
      end
      ST_MUL_GO: begin
        w.act = ACT_START;
        w.src = SRC_ACC_BASE;
      end
      ST_MUL_WAIT: begin
        w.act = ACT_WAIT;
        w.dst = DST_ACC;
      end
      ST_SQR_GO: begin
        w.act = ACT_START;
        w.src = SRC_BASE_BASE;
      end
      ST_SQR_WAIT: begin
        w.act = ACT_WAIT;
        w.dst = DST_BASE;
      end
      ST_LOOP: begin
        w.br     = BR_LOOP;
        w.target = ST_TEST;
      end
      ST_DONE: begin
        w.act = ACT_DONE;
      end
      ST_ZERO: begin
        w.act = ACT_ZERO;
      end
      default: begin
        // unused addresses finish with a zero result
        w.act = ACT_ZERO;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod: bit-serial modular multiplier
// Computes a * b mod m, scanning a from its top bit, one bit per cycle:
// r <- 2r mod m, then r <- r + b mod m when the bit is set. Needs b < m.
// ----------------------------------------------------------------------------
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OPERAND_BITS-1:0] a_i,
  input  logic [OPERAND_BITS-1:0] b_i,
  input  logic [OPERAND_BITS-1:0] mod_i,
  output logic                    done_o,
  output logic [OPERAND_BITS-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(OPERAND_BITS + 1);

  logic                    busy_q, busy_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [OPERAND_BITS-1:0] a_q, a_d;
  logic [OPERAND_BITS-1:0] b_q, b_d;
  logic [OPERAND_BITS-1:0] r_q, r_d;

  logic [OPERAND_BITS:0]   mod_ext;
  logic [OPERAND_BITS:0]   dbl;
  logic [OPERAND_BITS:0]   red1;
  logic [OPERAND_BITS:0]   sum;
  logic [OPERAND_BITS:0]   red2;

  // One step: double and reduce, add and reduce
  always_comb begin
    mod_ext = {1'b0, mod_i};
    dbl     = {r_q, 1'b0};
    red1    = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = a_q[OPERAND_BITS-1] ? (red1 + {1'b0, b_q}) : red1;
    red2    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = r_q;

  // Load on start, advance while bits remain, finish at zero
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(OPERAND_BITS);
      a_d    = a_i;
      b_d    = b_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CntW'(1);
        a_d   = {a_q[OPERAND_BITS-2:0], 1'b0};
        r_d   = red2[OPERAND_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

endmodule

// ===== rtl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation: message^exponent mod modulus
// Right-to-left square-and-multiply run by a small microprogram over a
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Set exponent (index 0) and modulus (index 1) over the cfg_* write channel
//   while the block is idle; cfg_ready_o is always high. Only the low
//   OPERAND_BITS bits of registers and message take part.
//   Raise start_i with message_i; the transfer happens when busy_o is low.
//   busy_o stays high until the result is out. done_o pulses for one cycle
//   with power_result_o; the receiver cannot stall, so it must take the
//   result in that cycle.
// Timing:
//   each modular multiplication in the serial multiplier is a start step
//   and then one bit per cycle. The exponent width and its set bits decide
//   when the result strobe comes after the start transfer. A modulus below
//   two gives result 0. One item is in flight at a time; the next start can
//   transfer in the strobe cycle.
// Reset:
//   exponent resets to 1, modulus to 2; the block comes up idle.
// ----------------------------------------------------------------------------
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = DataW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [DataW-1:0]   message_i,
  // Result channel
  output logic               done_o,
  output logic [DataW-1:0]   power_result_o,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned BitW = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
  localparam logic [BitW-1:0] LastBit = BitW'(OPERAND_BITS - 1);

  // Configuration registers
  logic [DataW-1:0] exp_q, mod_q;

  // Sequencer and datapath registers
  logic                    busy_q, busy_d;
  pc_t                     pc_q, pc_d;
  logic [BitW-1:0]         bit_q, bit_d;
  logic [OPERAND_BITS-1:0] msg_q, msg_d;
  logic [OPERAND_BITS-1:0] base_q, base_d;
  logic [OPERAND_BITS-1:0] acc_q, acc_d;
  logic                    done_q, done_d;
  logic [DataW-1:0]        res_q, res_d;

  logic [OPERAND_BITS-1:0] exp_w, mod_w;
  logic                    mod_small;
  logic                    ebit;
  logic                    accept;
  ctrl_word_t              word;

  logic                    mul_start;
  logic [OPERAND_BITS-1:0] mul_a, mul_b;
  logic                    mul_done;
  logic [OPERAND_BITS-1:0] mul_prod;

  assign cfg_ready_o = 1'b1;
  assign exp_w       = exp_q[OPERAND_BITS-1:0];
  assign mod_w       = mod_q[OPERAND_BITS-1:0];
  assign mod_small   = (mod_w[OPERAND_BITS-1:1] == '0);
  assign ebit        = exp_w[bit_q];
  assign accept      = start_i && !busy_q;
  assign word        = micro_rom(pc_q);

  assign busy_o         = busy_q;
  assign done_o         = done_q;
  assign power_result_o = res_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= DataW'(1);
      mod_q <= DataW'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_EXPONENT) begin
        exp_q <= cfg_data_i;
      end else if (cfg_index_i == REG_MODULUS) begin
        mod_q <= cfg_data_i;
      end
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (word.src)
      SRC_MSG_ONE: begin
        mul_a = msg_q;
        mul_b = OPERAND_BITS'(1);
      end
      SRC_ACC_BASE: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      SRC_BASE_BASE: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      default: begin
        mul_a = msg_q;
        mul_b = OPERAND_BITS'(1);
      end
    endcase
  end

  mexp_mulmod #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .mod_i  (mod_w),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Execute one control word per cycle while busy; a wait step holds until the product is ready
  always_comb begin
    busy_d    = busy_q;
    pc_d      = pc_q;
    bit_d     = bit_q;
    msg_d     = msg_q;
    base_d    = base_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    res_d     = res_q;
    mul_start = 1'b0;

    if (accept) begin
      busy_d = 1'b1;
      pc_d   = ST_INIT;
      msg_d  = message_i[OPERAND_BITS-1:0];
    end else if (busy_q) begin
      pc_d = pc_q + PcW'(1);

      unique case (word.act)
        ACT_NONE: begin
        end
        ACT_INIT: begin
          acc_d = OPERAND_BITS'(1);
          bit_d = '0;
        end
        ACT_START: begin
          mul_start = 1'b1;
        end
        ACT_WAIT: begin
          // hold until the product is ready
          if (!mul_done) begin
            pc_d = pc_q;
          end else if (word.dst == DST_ACC) begin
            acc_d = mul_prod;
          end else begin
            base_d = mul_prod;
          end
        end
        ACT_DONE: begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = DataW'(acc_q);
        end
        ACT_ZERO: begin
          busy_d = 1'b0;
          done_d = 1'b1;
          res_d  = '0;
        end
        default: begin
        end
      endcase

      unique case (word.br)
        BR_NEXT: begin
        end
        BR_MOD_SMALL: begin
          if (mod_small) pc_d = word.target;
        end
        BR_EBIT_ZERO: begin
          if (!ebit) pc_d = word.target;
        end
        BR_LOOP: begin
          // advance to the next exponent bit until the last one is done
          if (bit_q != LastBit) begin
            pc_d  = word.target;
            bit_d = bit_q + BitW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= ST_INIT;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    msg_q  <= msg_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

`ifndef SYNTHESIS
  // A result ends the run
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while still busy");

  // The multiplier only reports while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_done |-> busy_q)
    else $error("multiplier finished outside a run");

  // A result is reduced below the modulus, or zero for a tiny modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((mod_small && (power_result_o == '0)) ||
                (!mod_small && (power_result_o[OPERAND_BITS-1:0] < mod_w))))
    else $error("result not reduced");

  // Operands are loaded only while a run is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) mul_start |-> busy_q)
    else $error("multiplier started while idle");
`endif

endmodule
